/* design/tiered_block_cache_lru_manager_macros.svh */
// ----------------------------------------------------------------------------
// tiered block cache assertion macros
// immediate-implication and next-cycle checks clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef TIERED_BLOCK_CACHE_LRU_MANAGER_MACROS_SVH
`define TIERED_BLOCK_CACHE_LRU_MANAGER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbc same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbc next-cycle check failed");

`endif

/* design/tbc_pkg.sv */
// ----------------------------------------------------------------------------
// tbc_pkg
// shared constants, codes and types of the tiered block cache manager
// ----------------------------------------------------------------------------
`default_nettype none

package tbc_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int REF_BITS   = 16;
  localparam int NUM_TIERS  = 3;

  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int CMD_W    = 4;
  localparam int HND_W    = 32;
  localparam int TIER_W   = 2;
  localparam int SZ_W     = 48;
  localparam int REC_W    = 32;
  localparam int ST_W     = 3;
  localparam int OCNT_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(MAX_BLOCKS - 1);
  localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ACCESS  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_REF     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_UNREF   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PROMOTE = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DEMOTE  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_EVICT   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 4'd9;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_NOROOM   = 3'd2;
  localparam logic [ST_W-1:0] ST_BADDIR   = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIER1_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIER2_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIER3_CAP = 2'd2;

  localparam logic [TIER_W-1:0] TIER_SLOWEST = 2'd3;

  typedef struct packed {
    logic [HND_W-1:0]    handle;
    logic [TIER_W-1:0]   tier;
    logic [SZ_W-1:0]     size;
    logic [REF_BITS-1:0] refs;
    logic [REC_W-1:0]    recency;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_en;
    logic exec;
    logic ev_act;
    logic fin_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic is_evict;
    logic ev_stop;
  } dp_sts_t;

endpackage

`default_nettype wire

/* design/tbc_ifs.sv */
// ----------------------------------------------------------------------------
// tbc channel interfaces
// command and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tbc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tbc_pkg::CMD_W-1:0]     cmd;
  logic [tbc_pkg::HND_W-1:0]     block_id;
  logic [tbc_pkg::TIER_W-1:0]    tier_sel;
  logic [tbc_pkg::SZ_W-1:0]      req_size;
  modport source (output valid, cmd, block_id, tier_sel, req_size, input ready);
  modport sink (input valid, cmd, block_id, tier_sel, req_size, output ready);
endinterface

interface tbc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tbc_pkg::ST_W-1:0]      status;
  logic [tbc_pkg::HND_W-1:0]     out_handle;
  logic [tbc_pkg::SZ_W-1:0]      out_size;
  logic [tbc_pkg::OCNT_W-1:0]    evicted_count;
  logic [tbc_pkg::SZ_W-1:0]      tier_used;
  logic [tbc_pkg::OCNT_W-1:0]    tier_blocks;
  logic [tbc_pkg::OCNT_W-1:0]    all_blocks;
  modport source (output valid, status, out_handle, out_size, evicted_count,
                  tier_used, tier_blocks, all_blocks, input ready);
  modport sink (input valid, status, out_handle, out_size, evicted_count,
                tier_used, tier_blocks, all_blocks, output ready);
endinterface

`default_nettype wire

/* design/tbc_ctrl.sv */
// ----------------------------------------------------------------------------
// tbc_ctrl
// command sequencer: table scan, command execution, evict walk, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tbc_pkg::dp_cmd_t      dp_cmd,
  input  wire tbc_pkg::dp_sts_t dp_sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_ECHK = 3'd3;
  localparam logic [2:0] S_EACT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ev_phase_r, ev_phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    ev_phase_nxt = ev_phase_r;
    dp_cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load     = 1'b1;
          dp_cmd.scan_clr = 1'b1;
          ev_phase_nxt    = 1'b0;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        dp_cmd.scan_en = 1'b1;
        if (dp_sts.scan_done) begin
          if (ev_phase_r) state_nxt = S_EACT;
          else if (dp_sts.is_evict) state_nxt = S_ECHK;
          else state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt   = S_FIN;
      end
      S_ECHK: begin
        if (dp_sts.ev_stop) begin
          state_nxt = S_FIN;
        end else begin
          dp_cmd.scan_clr = 1'b1;
          ev_phase_nxt    = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_EACT: begin
        dp_cmd.ev_act = 1'b1;
        state_nxt     = S_ECHK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.fin_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.fin_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ev_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_phase_r  <= ev_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/tbc_dp.sv */
// ----------------------------------------------------------------------------
// tbc_dp
// block table, tier bookkeeping, scan capture and command effects
// ----------------------------------------------------------------------------
`default_nettype none

`include "tiered_block_cache_lru_manager_macros.svh"

module tbc_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tbc_pkg::dp_cmd_t                  cmd_i,
  output tbc_pkg::dp_sts_t                       sts_o,
  input  wire logic [tbc_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [tbc_pkg::HND_W-1:0]         in_id,
  input  wire logic [tbc_pkg::TIER_W-1:0]        in_tsel,
  input  wire logic [tbc_pkg::SZ_W-1:0]          in_size,
  input  wire logic                              cfg_we,
  input  wire logic [tbc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [tbc_pkg::SZ_W-1:0]          cfg_data,
  output logic [tbc_pkg::ST_W-1:0]               o_status,
  output logic [tbc_pkg::HND_W-1:0]              o_handle,
  output logic [tbc_pkg::SZ_W-1:0]               o_size,
  output logic [tbc_pkg::OCNT_W-1:0]             o_evicted,
  output logic [tbc_pkg::SZ_W-1:0]               o_tier_used,
  output logic [tbc_pkg::OCNT_W-1:0]             o_tier_blocks,
  output logic [tbc_pkg::OCNT_W-1:0]             o_all_blocks
);

  // latched command
  logic [tbc_pkg::CMD_W-1:0]  cmd_r;
  logic [tbc_pkg::HND_W-1:0]  id_r;
  logic [tbc_pkg::TIER_W-1:0] tsel_r;
  logic [tbc_pkg::SZ_W-1:0]   size_r;

  // table
  tbc_pkg::entry_t               mem [tbc_pkg::MAX_BLOCKS];
  logic [tbc_pkg::MAX_BLOCKS-1:0] valid_r, valid_nxt;
  tbc_pkg::entry_t               rd_r;
  logic [tbc_pkg::IDX_W-1:0]     rd_idx_r;
  logic                          rd_vld_r;
  logic [tbc_pkg::IDX_W-1:0]     scan_idx_r;
  logic                          iss_done_r;

  // scan capture
  logic                          m_found_r, f_found_r, o_found_r;
  logic [tbc_pkg::IDX_W-1:0]     m_slot_r, f_slot_r, o_slot_r;
  tbc_pkg::entry_t               m_ent_r, o_ent_r;
  logic [tbc_pkg::REC_W-1:0]     o_age_r;

  // tier bookkeeping
  logic [tbc_pkg::SZ_W-1:0]   cap_r  [tbc_pkg::NUM_TIERS];
  logic [tbc_pkg::SZ_W-1:0]   used_r [tbc_pkg::NUM_TIERS];
  logic [tbc_pkg::SZ_W-1:0]   used_nxt [tbc_pkg::NUM_TIERS];
  logic [tbc_pkg::CNT_W-1:0]  cnt_r  [tbc_pkg::NUM_TIERS];
  logic [tbc_pkg::CNT_W-1:0]  cnt_nxt [tbc_pkg::NUM_TIERS];
  logic [tbc_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [tbc_pkg::HND_W-1:0]  hc_r, hc_nxt;
  logic [tbc_pkg::REC_W-1:0]  rc_r, rc_nxt;
  logic [tbc_pkg::CNT_W-1:0]  skips_r, skips_nxt;
  logic [tbc_pkg::CNT_W-1:0]  evc_r, evc_nxt;
  logic [tbc_pkg::ST_W-1:0]   status_r, status_nxt;
  logic [tbc_pkg::HND_W-1:0]  handle_r, handle_nxt;
  logic [tbc_pkg::SZ_W-1:0]   osize_r, osize_nxt;

  // result register
  logic [tbc_pkg::ST_W-1:0]   res_status_r;
  logic [tbc_pkg::HND_W-1:0]  res_handle_r;
  logic [tbc_pkg::SZ_W-1:0]   res_size_r;
  logic [tbc_pkg::OCNT_W-1:0] res_evc_r;
  logic [tbc_pkg::SZ_W-1:0]   res_used_r;
  logic [tbc_pkg::OCNT_W-1:0] res_tblk_r;
  logic [tbc_pkg::OCNT_W-1:0] res_all_r;

  // table write port
  logic                       wr_en;
  logic [tbc_pkg::IDX_W-1:0]  wr_addr;
  tbc_pkg::entry_t            wr_data;

  logic                       tok;
  logic [tbc_pkg::TIER_W-1:0] tis, tns, src;
  logic [tbc_pkg::REC_W-1:0]  rc_inc;
  logic [tbc_pkg::REC_W-1:0]  age;
  logic                       lookup_cmd;
  logic                       ok_dir;

  assign tok    = (tsel_r != '0);
  assign tis    = tok ? (tsel_r - 2'd1) : 2'd0;
  assign tns    = (tsel_r == tbc_pkg::TIER_SLOWEST) ? 2'd0 : tsel_r;
  assign src    = (m_ent_r.tier != '0) ? (m_ent_r.tier - 2'd1) : 2'd0;
  assign rc_inc = rc_r + 32'd1;
  assign age    = rc_r - rd_r.recency;
  assign lookup_cmd = (cmd_r >= tbc_pkg::CMD_FREE) && (cmd_r <= tbc_pkg::CMD_DEMOTE);

  // status back to the controller
  assign sts_o.scan_done = rd_vld_r && (rd_idx_r == tbc_pkg::IDX_LAST);
  assign sts_o.is_evict  = (cmd_r == tbc_pkg::CMD_EVICT);
  assign sts_o.ev_stop   = !tok || (cnt_r[tis] == '0) || (used_r[tis] < cap_r[tis]) ||
                           (skips_r >= cnt_r[tis]);

  // command effects
  always_comb begin
    for (int t = 0; t < tbc_pkg::NUM_TIERS; t++) begin
      used_nxt[t] = used_r[t];
      cnt_nxt[t]  = cnt_r[t];
    end
    valid_nxt  = valid_r;
    total_nxt  = total_r;
    hc_nxt     = hc_r;
    rc_nxt     = rc_r;
    skips_nxt  = skips_r;
    evc_nxt    = evc_r;
    status_nxt = status_r;
    handle_nxt = handle_r;
    osize_nxt  = osize_r;
    wr_en      = 1'b0;
    wr_addr    = m_slot_r;
    wr_data    = m_ent_r;
    ok_dir     = 1'b0;

    if (cmd_i.load) begin
      skips_nxt  = '0;
      evc_nxt    = '0;
      status_nxt = tbc_pkg::ST_OK;
      handle_nxt = '0;
      osize_nxt  = '0;
    end

    if (cmd_i.exec) begin
      if (lookup_cmd) begin
        if (m_found_r) osize_nxt = m_ent_r.size;
        else status_nxt = tbc_pkg::ST_NOTFOUND;
      end
      case (cmd_r)
        tbc_pkg::CMD_ALLOC: begin
          if (!tok || ({1'b0, used_r[tis]} + {1'b0, size_r} > {1'b0, cap_r[tis]})) begin
            status_nxt = tbc_pkg::ST_NOROOM;
          end else if (!f_found_r) begin
            status_nxt = tbc_pkg::ST_FULL;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = f_slot_r;
            wr_data.handle  = hc_r;
            wr_data.tier    = tsel_r;
            wr_data.size    = size_r;
            wr_data.refs    = '0;
            wr_data.recency = rc_inc;
            rc_nxt          = rc_inc;
            hc_nxt          = (hc_r + 32'd1 == '0) ? 32'd1 : hc_r + 32'd1;
            valid_nxt[f_slot_r] = 1'b1;
            used_nxt[tis]   = used_r[tis] + size_r;
            cnt_nxt[tis]    = cnt_r[tis] + tbc_pkg::CNT_W'(1);
            total_nxt       = total_r + tbc_pkg::CNT_W'(1);
            handle_nxt      = hc_r;
            osize_nxt       = size_r;
          end
        end
        tbc_pkg::CMD_FREE: begin
          if (m_found_r) begin
            valid_nxt[m_slot_r] = 1'b0;
            used_nxt[src] = used_r[src] - m_ent_r.size;
            cnt_nxt[src]  = cnt_r[src] - tbc_pkg::CNT_W'(1);
            total_nxt     = total_r - tbc_pkg::CNT_W'(1);
          end
        end
        tbc_pkg::CMD_ACCESS: begin
          if (m_found_r) begin
            wr_en           = 1'b1;
            wr_data.recency = rc_inc;
            rc_nxt          = rc_inc;
          end
        end
        tbc_pkg::CMD_REF: begin
          if (m_found_r && (m_ent_r.refs != tbc_pkg::REF_MAX)) begin
            wr_en        = 1'b1;
            wr_data.refs = m_ent_r.refs + tbc_pkg::REF_BITS'(1);
          end
        end
        tbc_pkg::CMD_UNREF: begin
          if (m_found_r && (m_ent_r.refs != '0)) begin
            wr_en        = 1'b1;
            wr_data.refs = m_ent_r.refs - tbc_pkg::REF_BITS'(1);
          end
        end
        tbc_pkg::CMD_PROMOTE, tbc_pkg::CMD_DEMOTE: begin
          if (m_found_r) begin
            ok_dir = tok && ((cmd_r == tbc_pkg::CMD_PROMOTE) ? (tsel_r < m_ent_r.tier)
                                                             : (tsel_r > m_ent_r.tier));
            if (!ok_dir) begin
              status_nxt = tbc_pkg::ST_BADDIR;
            end else if ({1'b0, used_r[tis]} + {1'b0, m_ent_r.size} > {1'b0, cap_r[tis]}) begin
              status_nxt = tbc_pkg::ST_NOROOM;
            end else begin
              used_nxt[src]   = used_r[src] - m_ent_r.size;
              used_nxt[tis]   = used_r[tis] + m_ent_r.size;
              cnt_nxt[src]    = cnt_r[src] - tbc_pkg::CNT_W'(1);
              cnt_nxt[tis]    = cnt_r[tis] + tbc_pkg::CNT_W'(1);
              wr_en           = 1'b1;
              wr_data.tier    = tsel_r;
              wr_data.recency = rc_inc;
              rc_nxt          = rc_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // one evict step on the oldest block of the tier
    if (cmd_i.ev_act) begin
      wr_addr = o_slot_r;
      wr_data = o_ent_r;
      if (o_ent_r.refs != '0) begin
        wr_en           = 1'b1;
        wr_data.recency = rc_inc;
        rc_nxt          = rc_inc;
        skips_nxt       = skips_r + tbc_pkg::CNT_W'(1);
      end else begin
        used_nxt[tis] = used_r[tis] - o_ent_r.size;
        cnt_nxt[tis]  = cnt_r[tis] - tbc_pkg::CNT_W'(1);
        evc_nxt       = evc_r + tbc_pkg::CNT_W'(1);
        skips_nxt     = '0;
        if ((tsel_r != tbc_pkg::TIER_SLOWEST) &&
            ({1'b0, used_r[tns]} + {1'b0, o_ent_r.size} <= {1'b0, cap_r[tns]})) begin
          used_nxt[tns]   = used_r[tns] + o_ent_r.size;
          cnt_nxt[tns]    = cnt_r[tns] + tbc_pkg::CNT_W'(1);
          wr_en           = 1'b1;
          wr_data.tier    = tsel_r + 2'd1;
          wr_data.recency = rc_inc;
          rc_nxt          = rc_inc;
        end else begin
          valid_nxt[o_slot_r] = 1'b0;
          total_nxt           = total_r - tbc_pkg::CNT_W'(1);
        end
      end
    end
  end

  // table memory with registered read for the scan
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r     <= mem[scan_idx_r];
    rd_idx_r <= scan_idx_r;
  end

  // scan address sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      iss_done_r <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      scan_idx_r <= '0;
      iss_done_r <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd_i.scan_en && !iss_done_r;
      if (cmd_i.scan_en && !iss_done_r) begin
        if (scan_idx_r == tbc_pkg::IDX_LAST) iss_done_r <= 1'b1;
        else scan_idx_r <= scan_idx_r + tbc_pkg::IDX_W'(1);
      end
    end
  end

  // scan capture: handle match, first free slot, oldest of the tier
  always_ff @(posedge clk) begin
    if (cmd_i.scan_clr) begin
      m_found_r <= 1'b0;
      f_found_r <= 1'b0;
      o_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (valid_r[rd_idx_r]) begin
        if (!m_found_r && (id_r != '0) && (rd_r.handle == id_r)) begin
          m_found_r <= 1'b1;
          m_slot_r  <= rd_idx_r;
          m_ent_r   <= rd_r;
        end
        if ((rd_r.tier == tsel_r) && (!o_found_r || (age > o_age_r))) begin
          o_found_r <= 1'b1;
          o_slot_r  <= rd_idx_r;
          o_ent_r   <= rd_r;
          o_age_r   <= age;
        end
      end else if (!f_found_r) begin
        f_found_r <= 1'b1;
        f_slot_r  <= rd_idx_r;
      end
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r  <= in_cmd;
      id_r   <= in_id;
      tsel_r <= in_tsel;
      size_r <= in_size;
    end
  end

  // bookkeeping state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      total_r  <= '0;
      hc_r     <= 32'd1;
      rc_r     <= '0;
      skips_r  <= '0;
      evc_r    <= '0;
      status_r <= tbc_pkg::ST_OK;
      handle_r <= '0;
      osize_r  <= '0;
      for (int t = 0; t < tbc_pkg::NUM_TIERS; t++) begin
        used_r[t] <= '0;
        cnt_r[t]  <= '0;
        cap_r[t]  <= '0;
      end
    end else begin
      valid_r  <= valid_nxt;
      total_r  <= total_nxt;
      hc_r     <= hc_nxt;
      rc_r     <= rc_nxt;
      skips_r  <= skips_nxt;
      evc_r    <= evc_nxt;
      status_r <= status_nxt;
      handle_r <= handle_nxt;
      osize_r  <= osize_nxt;
      for (int t = 0; t < tbc_pkg::NUM_TIERS; t++) begin
        used_r[t] <= used_nxt[t];
        cnt_r[t]  <= cnt_nxt[t];
      end
      if (cfg_we) begin
        case (cfg_idx)
          tbc_pkg::REG_TIER1_CAP: cap_r[0] <= cfg_data;
          tbc_pkg::REG_TIER2_CAP: cap_r[1] <= cfg_data;
          tbc_pkg::REG_TIER3_CAP: cap_r[2] <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_i.fin_load) begin
      res_status_r <= status_r;
      res_handle_r <= handle_r;
      res_size_r   <= osize_r;
      res_evc_r    <= tbc_pkg::OCNT_W'(evc_r);
      res_used_r   <= tok ? used_r[tis] : '0;
      res_tblk_r   <= tok ? tbc_pkg::OCNT_W'(cnt_r[tis]) : '0;
      res_all_r    <= tbc_pkg::OCNT_W'(total_r);
    end
  end

  assign o_status      = res_status_r;
  assign o_handle      = res_handle_r;
  assign o_size        = res_size_r;
  assign o_evicted     = res_evc_r;
  assign o_tier_used   = res_used_r;
  assign o_tier_blocks = res_tblk_r;
  assign o_all_blocks  = res_all_r;

  // per-tier block counts always add up to the table total
  `TBC_ASSERT_NOW(a_count_sum, 1'b1, total_r == (cnt_r[0] + cnt_r[1] + cnt_r[2]))
  // every table write lands on an entry that is live afterwards
  `TBC_ASSERT_NEXT(a_write_live, wr_en, valid_r[$past(wr_addr)])
  // scan data only comes back for a read issued in the scan state
  `TBC_ASSERT_NOW(a_scan_issue, rd_vld_r, $past(cmd_i.scan_en))
  // live entries never exceed the table size
  `TBC_ASSERT_NOW(a_total_max, 1'b1, total_r <= tbc_pkg::CNT_W'(tbc_pkg::MAX_BLOCKS))

endmodule

`default_nettype wire

/* design/tiered_block_cache_lru_manager.sv */
// ----------------------------------------------------------------------------
// tiered_block_cache_lru_manager
// three-tier block table with LRU order, reference counts and tier evict
// ----------------------------------------------------------------------------
// Every command first sweeps the 64-entry block table through its single read
// port, one entry per cycle, with a registered read; all but evict then apply
// their effect before the result hand-off; one command is handled at a time.
// Evict repeats a check, a full sweep and one action on the tier's oldest block
// per step until no tier is selected, the tier is below capacity or empty, or a
// whole pass rotated only referenced blocks. A new command is taken while the
// previous result still waits on the output. Capacities are written through the
// cfg port while no command is in flight; the user must keep to this, as the
// block itself does not enforce it. No clearing pass is run.
`default_nettype none

module tiered_block_cache_lru_manager (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tbc_in_if.sink                             in_if,
  tbc_out_if.source                          out_if,
  input  wire logic                          cfg_we,
  input  wire logic [tbc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [tbc_pkg::SZ_W-1:0]      cfg_data
);

  tbc_pkg::dp_cmd_t dp_cmd;
  tbc_pkg::dp_sts_t dp_sts;

  // sequencer
  tbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  // table and bookkeeping
  tbc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .in_cmd        (in_if.cmd),
    .in_id         (in_if.block_id),
    .in_tsel       (in_if.tier_sel),
    .in_size       (in_if.req_size),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .o_status      (out_if.status),
    .o_handle      (out_if.out_handle),
    .o_size        (out_if.out_size),
    .o_evicted     (out_if.evicted_count),
    .o_tier_used   (out_if.tier_used),
    .o_tier_blocks (out_if.tier_blocks),
    .o_all_blocks  (out_if.all_blocks)
  );

endmodule

`default_nettype wire
